// ----- sv/est_pkg.sv -----
// Shared types, codes and constants of the expiring session table.
`timescale 1ns / 1ps
package est_pkg;

    localparam int DEF_TABLE_DEPTH = 64;

    localparam logic [30:0] TTL_RESET = 31'd3600;
    localparam logic [6:0]  MAX_RESET = 7'd64;

    localparam logic REG_TTL = 1'b0;
    localparam logic REG_MAX = 1'b1;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_CHECK  = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_ANON,
        KIND_CREATE,
        KIND_CHECK,
        KIND_REMOVE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] key;
        logic [31:0] now_sec;
    } t_item;

    typedef struct packed {
        logic        used;
        logic [31:0] created;
        logic [63:0] key;
    } t_entry;

endpackage

// ----- sv/est_front.sv -----
// Front end: input handshake, operation decode and a two-word queue to the back end.
`timescale 1ns / 1ps
module est_front import est_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic        i_anonymous,
    input  logic [63:0] i_key,
    input  logic [31:0] i_now_sec,
    input  logic        i_hold,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_pop
);

    t_item      r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_kind      kind;
    t_item      item;
    logic       push;
    logic       pop;

    always_comb begin
        unique case (i_func)
            FUNC_CREATE: kind = KIND_CREATE;
            FUNC_CHECK:  kind = KIND_CHECK;
            FUNC_REMOVE: kind = KIND_REMOVE;
            default:     kind = KIND_NOP;
        endcase
        if (i_anonymous && kind != KIND_NOP) begin
            kind = KIND_ANON;
        end
        item.kind    = kind;
        item.key     = i_key;
        item.now_sec = i_now_sec;
    end

    assign o_stall      = (r_cnt == 2'd2) || i_hold;
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- sv/est_back.sv -----
// Back end: table memory, sweep sequencer for expiry, oldest and key search, result register.
`timescale 1ns / 1ps
module est_back import est_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [30:0] i_ttl_seconds,
    input  logic [6:0]  i_max_entries,
    output logic        o_clearing,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic        o_evicted,
    output logic [63:0] o_evicted_key,
    output logic [6:0]  o_expired_removed,
    output logic [6:0]  o_live_count
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_EVICT = 6'b001000,
        S_FINAL = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    t_state  r_state;
    t_item   r_item;
    logic [IW-1:0] r_rd_idx;
    logic    r_issue;
    logic    r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    logic [LW-1:0] r_live;

    logic          r_best_found;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_age;
    logic [63:0]   r_best_key;
    logic          r_match_found;
    logic [IW-1:0] r_match_idx;
    logic          r_match_exp;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    logic        r_res_valid;
    logic        r_res_ev;
    logic [63:0] r_res_ev_key;
    logic [6:0]  r_res_removed;

    logic        r_out_valid;
    logic        r_out_valid_res;
    logic        r_out_ev;
    logic [63:0] r_out_ev_key;
    logic [6:0]  r_out_removed;
    logic [6:0]  r_out_live;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    logic [31:0]   age;
    logic          exp;
    logic          is_create;
    logic          drop;
    logic          live_e;
    logic          older;
    logic          match;
    logic          free_e;
    logic [CW-1:0] limit;
    logic          do_evict;
    logic          refresh;
    logic          slot_ok;
    logic [IW-1:0] slot;
    logic          load_out;

    assign age       = r_item.now_sec - r_rdata.created;
    assign exp       = age >= {1'b0, i_ttl_seconds};
    assign is_create = (r_item.kind == KIND_CREATE);
    assign drop      = r_rdata.used && is_create && exp;
    assign live_e    = r_rdata.used && !drop;
    assign free_e    = !live_e;
    assign match     = live_e && (r_rdata.key == r_item.key);
    assign older     = !r_best_found || (age > r_best_age)
                       || ((age == r_best_age) && (r_rdata.key < r_best_key));

    assign limit    = (CW'(i_max_entries) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(i_max_entries);
    assign do_evict = (r_live != '0) && (CW'(r_live) >= limit) && r_best_found;
    assign refresh  = r_match_found && !(r_res_ev && (r_match_idx == r_best_idx));
    assign slot_ok  = r_free_found || r_res_ev;
    assign slot     = (r_res_ev && (!r_free_found || (r_best_idx < r_free_idx)))
                      ? r_best_idx : r_free_idx;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) && i_item_valid;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmp_idx;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_rd_idx;
            end
            S_SWEEP: begin
                wr_en   = r_cmp_vld && drop;
                wr_addr = r_cmp_idx;
            end
            S_EVICT: begin
                wr_en   = is_create && do_evict;
                wr_addr = r_best_idx;
            end
            S_FINAL: begin
                unique case (r_item.kind)
                    KIND_CREATE: begin
                        wr_en        = refresh || slot_ok;
                        wr_addr      = refresh ? r_match_idx : slot;
                        wr_data.used = 1'b1;
                        wr_data.created = r_item.now_sec;
                        wr_data.key  = r_item.key;
                    end
                    KIND_CHECK: begin
                        wr_en   = r_match_found && r_match_exp;
                        wr_addr = r_match_idx;
                    end
                    KIND_REMOVE: begin
                        wr_en   = r_match_found;
                        wr_addr = r_match_idx;
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_rd_idx];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rd_idx  <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_live    <= '0;
        end else begin
            r_cmp_vld <= (r_state == S_SWEEP) && r_issue;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_rd_idx == IW'(TABLE_DEPTH - 1)) begin
                        r_rd_idx <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.kind == KIND_NOP || i_item.kind == KIND_ANON) begin
                            r_state <= S_DONE;
                        end else begin
                            r_rd_idx <= '0;
                            r_issue  <= 1'b1;
                            r_state  <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (r_issue) begin
                        if (r_rd_idx == IW'(TABLE_DEPTH - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    if (r_cmp_vld && drop) begin
                        r_live <= r_live - 1'b1;
                    end
                    if (r_cmp_vld && (r_cmp_idx == IW'(TABLE_DEPTH - 1))) begin
                        r_state <= is_create ? S_EVICT : S_FINAL;
                    end
                end
                S_EVICT: begin
                    if (do_evict) begin
                        r_live <= r_live - 1'b1;
                    end
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    unique case (r_item.kind)
                        KIND_CREATE: begin
                            if (!refresh && slot_ok) begin
                                r_live <= r_live + 1'b1;
                            end
                        end
                        KIND_CHECK: begin
                            if (r_match_found && r_match_exp) begin
                                r_live <= r_live - 1'b1;
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_match_found) begin
                                r_live <= r_live - 1'b1;
                            end
                        end
                        default: begin
                            r_live <= r_live;
                        end
                    endcase
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // item, search trackers and result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item        <= i_item;
            r_best_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_res_valid   <= (i_item.kind != KIND_NOP);
            r_res_ev      <= 1'b0;
            r_res_ev_key  <= '0;
            r_res_removed <= '0;
        end
        if (r_state == S_SWEEP) begin
            r_cmp_idx <= r_rd_idx;
        end
        if (r_state == S_SWEEP && r_cmp_vld) begin
            if (drop) begin
                r_res_removed <= r_res_removed + 7'd1;
            end
            if (live_e && older) begin
                r_best_found <= 1'b1;
                r_best_idx   <= r_cmp_idx;
                r_best_age   <= age;
                r_best_key   <= r_rdata.key;
            end
            if (match) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_cmp_idx;
                r_match_exp   <= exp;
            end
            if (free_e && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
        if (r_state == S_EVICT && do_evict) begin
            r_res_ev     <= 1'b1;
            r_res_ev_key <= r_best_key;
        end
        if (r_state == S_FINAL && r_item.kind == KIND_CHECK) begin
            r_res_valid <= r_match_found && !r_match_exp;
            if (r_match_found && r_match_exp) begin
                r_res_removed <= 7'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_valid_res <= r_res_valid;
            r_out_ev        <= r_res_ev;
            r_out_ev_key    <= r_res_ev_key;
            r_out_removed   <= r_res_removed;
            r_out_live      <= 7'(r_live);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_valid_res       = r_out_valid_res;
    assign o_evicted         = r_out_ev;
    assign o_evicted_key     = r_out_ev_key;
    assign o_expired_removed = r_out_removed;
    assign o_live_count      = r_out_live;

endmodule

// ----- sv/expiring_session_table.sv -----
// Top level of the expiring session table: configuration registers, front and back ends.
// Create, check and remove words sweep the table with one read per entry through the single read
//   port, then update; create adds an eviction step before the update.
// Anonymous and unused-code words skip the sweep. The back end takes one word at a time.
// Reset: control state and registers reset; then a clearing pass over every entry
//   empties the table, with input stalled (configuration writes still taken).
`timescale 1ns / 1ps
module expiring_session_table import est_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic        i_anonymous,
    input  logic [63:0] i_key,
    input  logic [31:0] i_now_sec,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic        o_evicted,
    output logic [63:0] o_evicted_key,
    output logic [6:0]  o_expired_removed,
    output logic [6:0]  o_live_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    logic [30:0] r_ttl_seconds;
    logic [6:0]  r_max_entries;
    logic        clearing;
    logic        item_valid;
    t_item       item;
    logic        pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_seconds <= TTL_RESET;
            r_max_entries <= MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TTL: r_ttl_seconds <= i_cfg_data;
                REG_MAX: r_max_entries <= i_cfg_data[6:0];
                default: r_ttl_seconds <= r_ttl_seconds;
            endcase
        end
    end

    est_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_func       (i_func),
        .i_anonymous  (i_anonymous),
        .i_key        (i_key),
        .i_now_sec    (i_now_sec),
        .i_hold       (clearing),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    est_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (item_valid),
        .i_item            (item),
        .o_pop             (pop),
        .i_ttl_seconds     (r_ttl_seconds),
        .i_max_entries     (r_max_entries),
        .o_clearing        (clearing),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_valid_res       (o_valid_res),
        .o_evicted         (o_evicted),
        .o_evicted_key     (o_evicted_key),
        .o_expired_removed (o_expired_removed),
        .o_live_count      (o_live_count)
    );

endmodule

// ----- sv/est_checker.sv -----
// Port-level checks of the expiring session table, bound to the top level.
`timescale 1ns / 1ps
module est_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_valid_res,
    input logic        o_evicted,
    input logic [63:0] o_evicted_key,
    input logic [6:0]  o_expired_removed,
    input logic [6:0]  o_live_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_valid_res)
            && $stable(o_evicted) && $stable(o_evicted_key)
            && $stable(o_expired_removed) && $stable(o_live_count))
        else $error("stalled result word changed");

    a_evict_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_valid_res)
        else $error("eviction reported on a word that is not valid");

    a_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_key == 64'd0)
        else $error("evicted key nonzero without eviction");

    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall && !o_out_valid)
        else $error("input not stalled during clearing pass");

endmodule

bind expiring_session_table est_checker u_est_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_valid_res       (o_valid_res),
    .o_evicted         (o_evicted),
    .o_evicted_key     (o_evicted_key),
    .o_expired_removed (o_expired_removed),
    .o_live_count      (o_live_count)
);
